// ===== hw/rtl/ccoa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccoa_pkg: shared types, widths and constants for the overlap-area block.
// Holds the CORDIC arctangent table, the field widths and the case codes.
// ----------------------------------------------------------------------------
package ccoa_pkg;

    localparam int COORD_WIDTH  = 16;
    localparam int RAD_WIDTH    = COORD_WIDTH - 1;
    localparam int SQ_GUARD     = (63 - 2 * COORD_WIDTH) / 2;
    localparam int EXT_BITS     = 8;
    localparam int CORDIC_STEPS = 32;
    localparam int SQRT_STEPS   = 32;
    localparam int QDEPTH       = 4;
    localparam int QPTR_W       = $clog2(QDEPTH);

    localparam logic [1:0] CASE_DISJOINT = 2'd0;
    localparam logic [1:0] CASE_CONTAIN  = 2'd1;
    localparam logic [1:0] CASE_LENS     = 2'd2;

    localparam logic [35:0] PI_Q32 = 36'h3243F6A88;
    localparam logic signed [33:0] QUARTER_TURN = 34'sh040000000;
    localparam logic [32:0] HALF_TURN = 33'h080000000;

    // Classified item handed from the front part to the back part
    typedef struct packed {
        logic [1:0]  kind;
        logic [29:0] rmin2;
        logic [29:0] r1sq;
        logic [29:0] r2sq;
        logic [33:0] d2;
        logic [33:0] p;
        logic [33:0] q;
    } item_t;

    function automatic logic [31:0] atan_bam(input logic [4:0] i);
        logic [31:0] t;
        case (i)
            5'd0:  t = 32'h20000000;  5'd1:  t = 32'h12E4051E;
            5'd2:  t = 32'h09FB385B;  5'd3:  t = 32'h051111D4;
            5'd4:  t = 32'h028B0D43;  5'd5:  t = 32'h0145D7E1;
            5'd6:  t = 32'h00A2F61E;  5'd7:  t = 32'h00517C55;
            5'd8:  t = 32'h0028BE53;  5'd9:  t = 32'h00145F2F;
            5'd10: t = 32'h000A2F98;  5'd11: t = 32'h000517CC;
            5'd12: t = 32'h00028BE6;  5'd13: t = 32'h000145F3;
            5'd14: t = 32'h0000A2FA;  5'd15: t = 32'h0000517D;
            5'd16: t = 32'h000028BE;  5'd17: t = 32'h0000145F;
            5'd18: t = 32'h00000A30;  5'd19: t = 32'h00000518;
            5'd20: t = 32'h0000028C;  5'd21: t = 32'h00000146;
            5'd22: t = 32'h000000A3;  5'd23: t = 32'h00000051;
            5'd24: t = 32'h00000029;  5'd25: t = 32'h00000014;
            5'd26: t = 32'h0000000A;  5'd27: t = 32'h00000005;
            5'd28: t = 32'h00000003;  5'd29: t = 32'h00000001;
            5'd30: t = 32'h00000001;  default: t = 32'h00000000;
        endcase
        return t;
    endfunction

endpackage

// ===== hw/rtl/ccoa_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccoa_front: input stage
// Registers one beat per cycle while the output is not stalled, squares distances and radii, and classifies
// the pair as disjoint, containment or lens.
// ----------------------------------------------------------------------------
module ccoa_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    // first_x[15:0], first_y[31:16], first_radius[46:32], second_x[62:47],
    // second_y[78:63], second_radius[93:79]
    input  logic [93:0]         in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output ccoa_pkg::item_t     out_item
);
    import ccoa_pkg::*;

    // stage 1: differences
    logic                  s1_valid_reg;
    logic [16:0]           adx_reg, ady_reg;
    logic [RAD_WIDTH-1:0]  r1_reg, r2_reg;
    // stage 2: classified item
    logic                  s2_valid_reg;
    item_t                 s2_item_reg;

    logic s2_adv, s1_adv;
    assign s2_adv   = !s2_valid_reg || out_ready;
    assign s1_adv   = !s1_valid_reg || s2_adv;
    assign in_ready = s1_adv;

    logic signed [16:0] dx, dy;
    always_comb begin
        dx = 17'(signed'(in_data[62:47])) - 17'(signed'(in_data[15:0]));
        dy = 17'(signed'(in_data[78:63])) - 17'(signed'(in_data[31:16]));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s1_adv) begin
            s1_valid_reg <= in_valid;
        end
        if (s1_adv && in_valid) begin
            adx_reg <= dx[16] ? 17'(-dx) : 17'(dx);
            ady_reg <= dy[16] ? 17'(-dy) : 17'(dy);
            r1_reg  <= in_data[46:32];
            r2_reg  <= in_data[93:79];
        end
    end

    // classification
    logic [33:0] d2, sum2, diff2;
    logic [15:0] sum;
    logic [14:0] diff, rmin;
    item_t       it;
    always_comb begin
        d2    = 34'(adx_reg) * 34'(adx_reg) + 34'(ady_reg) * 34'(ady_reg);
        sum   = 16'(r1_reg) + 16'(r2_reg);
        diff  = (r1_reg > r2_reg) ? r1_reg - r2_reg : r2_reg - r1_reg;
        rmin  = (r1_reg < r2_reg) ? r1_reg : r2_reg;
        sum2  = 34'(sum) * 34'(sum);
        diff2 = 34'(diff) * 34'(diff);
        it.rmin2 = 30'(rmin) * 30'(rmin);
        it.r1sq  = 30'(r1_reg) * 30'(r1_reg);
        it.r2sq  = 30'(r2_reg) * 30'(r2_reg);
        it.d2    = d2;
        it.p     = d2 - diff2;
        it.q     = sum2 - d2;
        if (d2 >= sum2)       it.kind = CASE_DISJOINT;
        else if (d2 <= diff2) it.kind = CASE_CONTAIN;
        else                  it.kind = CASE_LENS;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (s2_adv) begin
            s2_valid_reg <= s1_valid_reg;
        end
        if (s2_adv && s1_valid_reg) s2_item_reg <= it;
    end

    assign out_valid = s2_valid_reg;
    assign out_item  = s2_item_reg;
endmodule

// ===== hw/rtl/ccoa_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccoa_queue: short FIFO between the front and back parts
// Four entries of classified items, full throughput.
// ----------------------------------------------------------------------------
module ccoa_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  ccoa_pkg::item_t   in_item,
    output logic              out_valid,
    input  logic              out_ready,
    output ccoa_pkg::item_t   out_item
);
    import ccoa_pkg::*;

    item_t            mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_reg, rd_reg;
    logic [QPTR_W:0]   cnt_reg;
    logic wr, rd;

    assign in_ready  = (cnt_reg != (QPTR_W+1)'(QDEPTH));
    assign out_valid = (cnt_reg != '0);
    assign out_item  = mem_reg[rd_reg];
    assign wr = in_valid && in_ready;
    assign rd = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (wr) wr_reg <= wr_reg + 1'b1;
            if (rd) rd_reg <= rd_reg + 1'b1;
            cnt_reg <= cnt_reg + (QPTR_W+1)'(wr) - (QPTR_W+1)'(rd);
        end
        if (wr) mem_reg[wr_reg] <= in_item;
    end
endmodule

// ===== hw/rtl/ccoa_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccoa_back: area pipeline
// Square roots (one bit per stage), product, two CORDIC rotators (one
// iteration per stage), radian scaling and the final area sum.
// ----------------------------------------------------------------------------
module ccoa_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  ccoa_pkg::item_t   in_item,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [31:0]       out_area,
    output logic [1:0]        out_case
);
    import ccoa_pkg::*;

    // Pipeline: all stages advance together on en
    localparam int NS = SQRT_STEPS + 1 + 1 + CORDIC_STEPS + 5;

    logic en;
    logic [NS-1:0] v_reg;
    assign en       = !v_reg[NS-1] || out_ready;
    assign in_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) v_reg <= '0;
        else if (en)  v_reg <= {v_reg[NS-2:0], in_valid};
    end

    // ---------------- square roots: 32 stages, one result bit each ----------
    typedef struct packed {
        logic [1:0]  kind;
        logic [29:0] rmin2;
        logic [29:0] r1sq;
        logic [29:0] r2sq;
        logic signed [35:0] n1;
        logic signed [35:0] n2;
    } side_t;

    typedef struct packed {
        logic [63:0] rem;
        logic [63:0] res;
    } sq_t;

    side_t sd_reg [SQRT_STEPS];
    sq_t   sp_reg [SQRT_STEPS];
    sq_t   sq_reg [SQRT_STEPS];

    function automatic sq_t sq_step(input sq_t a, input int k);
        sq_t o;
        logic [63:0] bitv, t;
        bitv = 64'd1 << (62 - 2 * k);
        t = a.res + bitv;
        if (a.rem >= t) begin
            o.rem = a.rem - t;
            o.res = (a.res >> 1) + bitv;
        end else begin
            o.rem = a.rem;
            o.res = a.res >> 1;
        end
        return o;
    endfunction

    side_t sd_in;
    sq_t   sp_in, sq_in;
    always_comb begin
        sd_in.kind  = in_item.kind;
        sd_in.rmin2 = in_item.rmin2;
        sd_in.r1sq  = in_item.r1sq;
        sd_in.r2sq  = in_item.r2sq;
        sd_in.n1 = 36'(in_item.d2) + 36'(in_item.r1sq) - 36'(in_item.r2sq);
        sd_in.n2 = 36'(in_item.d2) + 36'(in_item.r2sq) - 36'(in_item.r1sq);
        sp_in.rem = 64'(in_item.p) << (2 * SQ_GUARD);
        sp_in.res = '0;
        sq_in.rem = 64'(in_item.q) << (2 * SQ_GUARD);
        sq_in.res = '0;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sd_reg[0] <= sd_in;
            sp_reg[0] <= sq_step(sp_in, 0);
            sq_reg[0] <= sq_step(sq_in, 0);
            for (int k = 1; k < SQRT_STEPS; k++) begin
                sd_reg[k] <= sd_reg[k-1];
                sp_reg[k] <= sq_step(sp_reg[k-1], k);
                sq_reg[k] <= sq_step(sq_reg[k-1], k);
            end
        end
    end

    // ---------------- product S = sqrt(P) * sqrt(Q) -------------------------
    side_t       m_sd_reg;
    logic [63:0] s_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            m_sd_reg <= sd_reg[SQRT_STEPS-1];
            s_reg    <= 64'(sp_reg[SQRT_STEPS-1].res[31:0])
                      * 64'(sq_reg[SQRT_STEPS-1].res[31:0]);
        end
    end

    // ---------------- normalize operands for CORDIC -------------------------
    typedef struct packed {
        logic signed [60:0] x;
        logic signed [60:0] y;
        logic signed [33:0] z;
    } cv_t;

    // Shift the pair so that x | y lies in [2^57, 2^58), by a search for its top set bit
    function automatic cv_t norm(input logic [63:0] xi, input logic [63:0] y);
        cv_t o;
        logic [63:0] x, t;
        int sh;
        x = xi;
        t = x | y;
        sh = 0;
        for (int i = 63; i >= 0; i--) if (t[i] && sh == 0) sh = i + 1;
        if (sh > 58) begin
            x = x >> (sh - 58);
            y = y >> (sh - 58);
        end else if (sh != 0) begin
            x = x << (58 - sh);
            y = y << (58 - sh);
        end
        o.x = 61'(x);
        o.y = 61'(y);
        o.z = '0;
        return o;
    endfunction

    side_t n_sd_reg;
    cv_t   c1_in_reg, c2_in_reg;
    logic [63:0] n_s_reg;
    logic [63:0] an1, an2;
    always_comb begin
        an1 = m_sd_reg.n1[35] ? 64'(-m_sd_reg.n1) : 64'(m_sd_reg.n1);
        an2 = m_sd_reg.n2[35] ? 64'(-m_sd_reg.n2) : 64'(m_sd_reg.n2);
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            n_sd_reg  <= m_sd_reg;
            n_s_reg   <= s_reg;
            c1_in_reg <= norm(an1 << (2 * SQ_GUARD), s_reg);
            c2_in_reg <= norm(an2 << (2 * SQ_GUARD), s_reg);
        end
    end

    // ---------------- CORDIC: one iteration per stage -----------------------
    function automatic cv_t cstep(input cv_t a, input int i);
        cv_t o;
        logic [31:0] ang;
        ang = atan_bam(5'(i));
        if (a.y > 0) begin
            o.x = a.x + (a.y >>> i);
            o.y = a.y - (a.x >>> i);
            o.z = a.z + 34'(ang);
        end else begin
            o.x = a.x - (a.y >>> i);
            o.y = a.y + (a.x >>> i);
            o.z = a.z - 34'(ang);
        end
        return o;
    endfunction

    side_t       cs_reg [CORDIC_STEPS];
    logic [63:0] cs_s_reg [CORDIC_STEPS];
    cv_t         c1_reg [CORDIC_STEPS];
    cv_t         c2_reg [CORDIC_STEPS];
    always_ff @(posedge aclk) begin
        if (en) begin
            cs_reg[0]   <= n_sd_reg;
            cs_s_reg[0] <= n_s_reg;
            c1_reg[0]   <= cstep(c1_in_reg, 0);
            c2_reg[0]   <= cstep(c2_in_reg, 0);
            for (int i = 1; i < CORDIC_STEPS; i++) begin
                cs_reg[i]   <= cs_reg[i-1];
                cs_s_reg[i] <= cs_s_reg[i-1];
                c1_reg[i]   <= cstep(c1_reg[i-1], i);
                c2_reg[i]   <= cstep(c2_reg[i-1], i);
            end
        end
    end

    // ---------------- clamp, fold and convert to radians --------------------
    function automatic logic [32:0] fold(input logic signed [33:0] z,
                                         input logic neg);
        logic signed [33:0] c;
        c = z;
        if (c < 0) c = '0;
        if (c > QUARTER_TURN) c = QUARTER_TURN;
        return neg ? HALF_TURN - 33'(c) : 33'(c);
    endfunction

    side_t       a_sd_reg;
    logic [63:0] a_s_reg;
    logic [32:0] ang1_reg, ang2_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            a_sd_reg <= cs_reg[CORDIC_STEPS-1];
            a_s_reg  <= cs_s_reg[CORDIC_STEPS-1];
            ang1_reg <= fold(c1_reg[CORDIC_STEPS-1].z, cs_reg[CORDIC_STEPS-1].n1[35]);
            ang2_reg <= fold(c2_reg[CORDIC_STEPS-1].z, cs_reg[CORDIC_STEPS-1].n2[35]);
        end
    end

    // angle * pi, round half up at 2^31
    side_t       r_sd_reg;
    logic [63:0] r_s_reg;
    logic [68:0] rp1_reg, rp2_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            r_sd_reg <= a_sd_reg;
            r_s_reg  <= a_s_reg;
            rp1_reg  <= 69'(ang1_reg) * 69'(PI_Q32);
            rp2_reg  <= 69'(ang2_reg) * 69'(PI_Q32);
        end
    end

    logic [37:0] rad1, rad2;
    assign rad1 = 38'((rp1_reg + 69'(32'h40000000)) >> 31);
    assign rad2 = 38'((rp2_reg + 69'(32'h40000000)) >> 31);

    // r^2 * rad terms, containment area
    side_t       t_sd_reg;
    logic [63:0] t_s_reg;
    logic [67:0] tp1_reg, tp2_reg;
    logic [65:0] cp_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            t_sd_reg <= r_sd_reg;
            t_s_reg  <= r_s_reg;
            tp1_reg  <= 68'(r_sd_reg.r1sq) * 68'(rad1);
            tp2_reg  <= 68'(r_sd_reg.r2sq) * 68'(rad2);
            cp_reg   <= 66'(r_sd_reg.rmin2) * 66'(PI_Q32);
        end
    end

    // terms minus triangle
    logic [1:0]  k_kind_reg;
    logic [44:0] ext_reg;
    logic [33:0] ca_reg;
    logic [44:0] t1, t2, tri_v, acc;
    always_comb begin
        t1    = 45'(tp1_reg >> (32 - EXT_BITS));
        t2    = 45'(tp2_reg >> (32 - EXT_BITS));
        tri_v = 45'(t_s_reg >> (2 * SQ_GUARD - EXT_BITS + 1));
        acc   = t1 + t2;
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            k_kind_reg <= t_sd_reg.kind;
            ext_reg    <= (acc > tri_v) ? acc - tri_v : '0;
            ca_reg     <= 34'((cp_reg + 66'(32'h80000000)) >> 32);
        end
    end

    // final rounding, saturation and case select
    logic [36:0] lens;
    logic [31:0] area_next;
    always_comb begin
        lens = 37'((ext_reg + 45'(1 << (EXT_BITS - 1))) >> EXT_BITS);
        case (k_kind_reg)
            CASE_CONTAIN: area_next = (ca_reg > 34'hFFFFFFFF) ? 32'hFFFFFFFF
                                                               : ca_reg[31:0];
            CASE_LENS:    area_next = (lens > 37'hFFFFFFFF) ? 32'hFFFFFFFF
                                                             : lens[31:0];
            default:      area_next = '0;
        endcase
    end

    logic [31:0] area_reg;
    logic [1:0]  case_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            area_reg <= area_next;
            case_reg <= k_kind_reg;
        end
    end

    assign out_valid = v_reg[NS-1];
    assign out_area  = area_reg;
    assign out_case  = case_reg;
endmodule

// ===== hw/rtl/circle_circle_overlap_area.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circle_circle_overlap_area: intersection area of two circles
// One input beat carries two circles; one output beat carries the overlap
// area (unsigned Q32.0 integer, saturating) and a case code (disjoint,
// contained, lens).
// Channels: s_axis (tvalid/tready/tdata) in, m_axis (tvalid/tready/tdata/
// tuser) out. A beat moves when tvalid and tready are both high.
// Throughput: one beat per cycle, sustained while m_axis_tready stays high.
// Path: the front classifier, then the queue, then the back pipeline (32
// square-root stages, 32 CORDIC stages, plus product, normalize, fold,
// radian, term, difference and output stages).
// The front and back are joined by a 4-entry queue so each can stall alone.
// Reset (aresetn low, synchronous) empties every stage and the queue.
// When m_axis_tready is low the back pipeline holds, the queue fills, then
// the front holds and s_axis_tready drops. No item is lost or repeated.
// ----------------------------------------------------------------------------
module circle_circle_overlap_area (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // first_x[15:0], first_y[31:16], first_radius[46:32], second_x[62:47],
    // second_y[78:63], second_radius[93:79], zero pad [95:94]
    input  logic [95:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // overlap_area[31:0]
    output logic [31:0] m_axis_tdata,
    // overlap_case[1:0]
    output logic [1:0]  m_axis_tuser
);
    import ccoa_pkg::*;

    logic  f_valid, f_ready, b_valid, b_ready;
    item_t f_item, b_item;

    ccoa_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_data   (s_axis_tdata[93:0]),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .out_item  (f_item)
    );

    ccoa_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_item   (f_item),
        .out_valid (b_valid),
        .out_ready (b_ready),
        .out_item  (b_item)
    );

    ccoa_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (b_valid),
        .in_ready  (b_ready),
        .in_item   (b_item),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_area  (m_axis_tdata),
        .out_case  (m_axis_tuser)
    );
endmodule

// ===== tb/ccoa_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccoa_checker: overlap-area predictor and scoreboard
// Watches both channels of the overlap-area block, computes the expected area
// and case code of every accepted input beat, and compares each output beat
// with the oldest prediction.
// ----------------------------------------------------------------------------
module ccoa_checker
    import ccoa_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [95:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,
    input  logic [1:0]  m_axis_tuser,
    output int          fail_count,
    output int          pending_count
);

    typedef struct packed {
        logic [31:0] area;
        logic [1:0]  kind;
    } overlap_t;

    localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

    overlap_t overlap_q[$];

    // floor(a*b / 2^s), saturating
    function automatic logic [63:0] scaled_product(logic [63:0] a, logic [63:0] b, int s);
        logic [127:0] full;
        full = ({64'd0, a} * {64'd0, b}) >> s;
        return (full[127:64] != 0) ? ALL_ONES : full[63:0];
    endfunction

    // round half up of a*b / 2^s
    function automatic logic [63:0] rounded_product(logic [63:0] a, logic [63:0] b, int s);
        logic [63:0] t;
        t = scaled_product(a, b, s - 1);
        if (t == ALL_ONES) return t >> 1;
        return (t + 64'd1) >> 1;
    endfunction

    function automatic logic [63:0] floor_sqrt(logic [63:0] v);
        logic [63:0] rem, res, bt;
        rem = v;
        res = 0;
        bt  = 64'd1 << 62;
        while (bt > rem) bt >>= 2;
        while (bt != 0) begin
            if (rem >= res + bt) begin
                rem -= res + bt;
                res = (res >> 1) + bt;
            end else begin
                res >>= 1;
            end
            bt >>= 2;
        end
        return res;
    endfunction

    // vectoring CORDIC, first quadrant, binary angle clamped to a quarter turn
    function automatic logic signed [63:0] quadrant_angle(logic [63:0] x, logic [63:0] y);
        logic signed [63:0] vx, vy, nx, ny, z;
        z = 0;
        while ((x | y) >= (64'd1 << 58)) begin
            x >>= 1;
            y >>= 1;
        end
        while ((x | y) != 0 && (x | y) < (64'd1 << 57)) begin
            x <<= 1;
            y <<= 1;
        end
        vx = x;
        vy = y;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            if (vy > 0) begin
                nx = vx + (vy >>> i);
                ny = vy - (vx >>> i);
                z += {32'd0, atan_bam(5'(i))};
            end else begin
                nx = vx - (vy >>> i);
                ny = vy + (vx >>> i);
                z -= {32'd0, atan_bam(5'(i))};
            end
            vx = nx;
            vy = ny;
        end
        if (z < 0) z = 0;
        if (z > 64'sh40000000) z = 64'sh40000000;
        return z;
    endfunction

    function automatic logic [63:0] chord_angle(logic signed [63:0] n, logic [63:0] s);
        logic [63:0] an;
        logic signed [63:0] z;
        an = (n < 0) ? -n : n;
        z = quadrant_angle(an << (2 * SQ_GUARD), s);
        return (n < 0) ? (64'h80000000 - z) : z;
    endfunction

    function automatic overlap_t predict_overlap(logic [95:0] beat);
        logic signed [63:0] x1, y1, x2, y2, dx, dy, n1, n2;
        logic [63:0] r1, r2, d2, sum, diff, rmin, area, p, q, s;
        logic [63:0] rad1, rad2, t1, t2, tri_part, acc, ext;
        overlap_t res;
        x1 = 64'(signed'(beat[15:0]));
        y1 = 64'(signed'(beat[31:16]));
        r1 = 64'(beat[46:32]);
        x2 = 64'(signed'(beat[62:47]));
        y2 = 64'(signed'(beat[78:63]));
        r2 = 64'(beat[93:79]);
        dx = x2 - x1;
        dy = y2 - y1;
        d2 = dx * dx + dy * dy;
        sum = r1 + r2;
        diff = (r1 > r2) ? r1 - r2 : r2 - r1;
        rmin = (r1 < r2) ? r1 : r2;
        if (d2 >= sum * sum) begin
            area = 0;
            res.kind = CASE_DISJOINT;
        end else if (d2 <= diff * diff) begin
            area = rounded_product(rmin * rmin, 64'(PI_Q32), 32);
            res.kind = CASE_CONTAIN;
        end else begin
            p = d2 - diff * diff;
            q = sum * sum - d2;
            s = floor_sqrt(p << (2 * SQ_GUARD)) * floor_sqrt(q << (2 * SQ_GUARD));
            n1 = d2 + r1 * r1 - r2 * r2;
            n2 = d2 + r2 * r2 - r1 * r1;
            rad1 = rounded_product(chord_angle(n1, s), 64'(PI_Q32), 31);
            rad2 = rounded_product(chord_angle(n2, s), 64'(PI_Q32), 31);
            t1 = scaled_product(r1 * r1, rad1, 32 - EXT_BITS);
            t2 = scaled_product(r2 * r2, rad2, 32 - EXT_BITS);
            tri_part = s >> (2 * SQ_GUARD - EXT_BITS + 1);
            acc = (t1 > ALL_ONES - t2) ? ALL_ONES : t1 + t2;
            ext = (acc > tri_part) ? acc - tri_part : 0;
            if (ext > ALL_ONES - (64'd1 << (EXT_BITS - 1)))
                area = ALL_ONES >> EXT_BITS;
            else
                area = (ext + (64'd1 << (EXT_BITS - 1))) >> EXT_BITS;
            res.kind = CASE_LENS;
        end
        res.area = (area > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : area[31:0];
        return res;
    endfunction

    assign pending_count = overlap_q.size();

    // predict on input beats, compare on output beats
    always @(posedge aclk) begin
        overlap_t exp_ov;
        int       errs;
        errs = 0;
        if (!aresetn) begin
            fail_count <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                overlap_q.push_back(predict_overlap(s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready) begin
                if (overlap_q.size() == 0) begin
                    $error("unexpected output beat: area %h case %0d",
                           m_axis_tdata, m_axis_tuser);
                    errs++;
                end else begin
                    exp_ov = overlap_q.pop_front();
                    if (exp_ov.area !== m_axis_tdata) begin
                        $error("overlap_area: expected %h, actual %h",
                               exp_ov.area, m_axis_tdata);
                        errs++;
                    end
                    if (exp_ov.kind !== m_axis_tuser) begin
                        $error("overlap_case: expected %0d, actual %0d",
                               exp_ov.kind, m_axis_tuser);
                        errs++;
                    end
                end
            end
            fail_count <= fail_count + errs;
        end
    end

endmodule

// ===== tb/circle_circle_overlap_area_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circle_circle_overlap_area_tb: overlap-area block regression
// Drives directed circle pairs (extremes, tangency, containment, equal
// circles, minimum radii) and then random pairs biased toward overlap, with
// bursty input and a stalling output; a checker module scores every beat.
// ----------------------------------------------------------------------------
module circle_circle_overlap_area_tb;
    import ccoa_pkg::*;

    localparam int RANDOM_PAIRS = 1400;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int LATENCY      = 74;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    int          fail_count;
    int          pending_count;
    int          cycle_count = 0;
    bit          long_hold = 1'b0;

    always #10 aclk = ~aclk;

    circle_circle_overlap_area i_dut (.*);

    ccoa_checker i_checker (.*);

    function automatic logic [95:0] pack_pair(logic [15:0] x1, logic [15:0] y1,
                                              logic [14:0] r1, logic [15:0] x2,
                                              logic [15:0] y2, logic [14:0] r2);
        return {2'b00, r2, y2, x2, r1, y1, x1};
    endfunction

    // random pair: mostly close centers of mixed sizes so lenses dominate
    function automatic logic [95:0] random_pair();
        logic [15:0] x1, y1, x2, y2;
        logic [14:0] r1, r2;
        int span;
        x1 = 16'($urandom);
        y1 = 16'($urandom);
        r1 = 15'($urandom_range(1, 32767));
        r2 = 15'($urandom_range(1, 32767));
        case ($urandom_range(0, 4))
            0: begin
                x2 = 16'($urandom);
                y2 = 16'($urandom);
            end
            1: begin
                r1 = 15'($urandom_range(1, 64));
                r2 = 15'($urandom_range(1, 64));
                x2 = x1 + 16'($urandom_range(0, 160)) - 16'd80;
                y2 = y1 + 16'($urandom_range(0, 160)) - 16'd80;
            end
            default: begin
                span = r1 + r2;
                x2 = x1 + 16'($urandom_range(0, span)) - 16'(span / 2);
                y2 = y1 + 16'($urandom_range(0, span)) - 16'(span / 2);
            end
        endcase
        return pack_pair(x1, y1, r1, x2, y2, r2);
    endfunction

    // one beat, held until accepted
    task automatic send_pair(logic [95:0] beat);
        s_axis_tdata  <= beat;
        s_axis_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
    endtask

    task automatic idle_gap(int n);
        s_axis_tvalid <= 1'b0;
        repeat (n) @(posedge aclk);
    endtask

    // receiver stall pattern, with one long hold-off
    always @(posedge aclk) begin
        int hold_cnt;
        if (long_hold) begin
            m_axis_tready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt = hold_cnt - 1;
            m_axis_tready <= 1'b0;
        end else if ((cycle_count / 3000) % 3 == 0) begin
            m_axis_tready <= 1'b1;
        end else begin
            if ($urandom_range(0, 9) == 0) hold_cnt = $urandom_range(1, 12);
            m_axis_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    // long hold-off counted in its own process, while random beats flow
    initial begin
        wait (cycle_count == 600);
        @(posedge aclk);
        long_hold <= 1'b1;
        repeat (300) @(posedge aclk);
        long_hold <= 1'b0;
    end

    // timeout
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        logic [15:0] neg_max, pos_max;
        int burst;
        neg_max = 16'h8000;
        pos_max = 16'h7FFF;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: extremes, tangency, containment, equal circles
        send_pair(pack_pair(neg_max, neg_max, 15'h7FFF, pos_max, pos_max, 15'h7FFF));
        send_pair(pack_pair(neg_max, neg_max, 15'd1, pos_max, pos_max, 15'd1));
        send_pair(pack_pair(16'd0, 16'd0, 15'h7FFF, 16'd0, 16'd0, 15'h7FFF));
        send_pair(pack_pair(16'd0, 16'd0, 15'h7FFF, 16'd0, 16'd0, 15'd1));
        send_pair(pack_pair(16'd0, 16'd0, 15'd1, 16'd0, 16'd0, 15'd1));
        send_pair(pack_pair(16'd0, 16'd0, 15'd256, 16'd512, 16'd0, 15'd256));
        send_pair(pack_pair(16'd0, 16'd0, 15'd512, 16'd256, 16'd0, 15'd256));
        send_pair(pack_pair(16'd0, 16'd0, 15'd300, 16'd300, 16'd0, 15'd300));
        send_pair(pack_pair(16'd0, 16'd0, 15'd300, 16'd0, 16'd400, 15'd500));
        send_pair(pack_pair(pos_max, 16'd0, 15'h7FFF, neg_max, 16'd0, 15'h7FFF));
        send_pair(pack_pair(16'd0, pos_max, 15'h7FFF, 16'd0, neg_max, 15'h7FFF));
        send_pair(pack_pair(16'd0, 16'd0, 15'h7FFF, 16'd100, 16'd0, 15'h7FFF));
        send_pair(pack_pair(16'd0, 16'd0, 15'd1, 16'd1, 16'd0, 15'd1));
        send_pair(pack_pair(16'd0, 16'd0, 15'd2, 16'd1, 16'd1, 15'd1));
        send_pair(pack_pair(16'hFFFF, 16'hFFFF, 15'h4000, 16'd0, 16'd0, 15'h2AAA));
        send_pair(pack_pair(16'h5555, 16'hAAAA, 15'h5555, 16'h5500, 16'hAA00, 15'h2AAA));
        // pause until drained
        s_axis_tvalid <= 1'b0;
        wait (pending_count == 0);
        @(posedge aclk);

        // random part in bursts
        for (int n = 0; n < RANDOM_PAIRS; ) begin
            burst = $urandom_range(1, 40);
            for (int k = 0; k < burst && n < RANDOM_PAIRS; k++, n++)
                send_pair(random_pair());
            if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 15));
        end
        s_axis_tvalid <= 1'b0;

        wait (pending_count == 0);
        repeat (LATENCY + 20) @(posedge aclk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/ccoa_pkg.sv
hw/rtl/ccoa_front.sv
hw/rtl/ccoa_queue.sv
hw/rtl/ccoa_back.sv
hw/rtl/circle_circle_overlap_area.sv
tb/ccoa_checker.sv
tb/circle_circle_overlap_area_tb.sv
